FILE: rtl/core/dcut_pkg.sv
// Shared types and constants for the summer-time check and UTC conversion block.
// No dependencies; imported by every module under rtl/core.
package dcut_pkg;

    // Time source codes
    localparam logic [1:0] SRC_DCF77 = 2'd0;
    localparam logic [1:0] SRC_MSF60 = 2'd1;
    localparam logic [1:0] SRC_WWVB  = 2'd2;
    localparam logic [1:0] SRC_JJY   = 2'd3;

    // Months that matter to the switch rules
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;

    localparam logic [4:0]  DAY_LAST      = 5'd31;
    localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
    localparam logic [12:0] YEAR_SHIFT    = 13'd400;
    // floor(x * RECIP100 / 2^19) == floor(x / 100) for x below 4500
    localparam logic [12:0] RECIP100      = 13'd5243;

    // Request to the Sunday scanner
    typedef struct packed {
        logic       start;
        logic       down;   // 1: last Sunday from day 31, 0: n-th Sunday from day 1
        logic [1:0] nth;
    } t_scan_ctl;

    // Sakamoto month key
    function automatic logic [2:0] month_key(input logic [3:0] m);
        logic [2:0] k;
        case (m)
            4'd1:    k = 3'd0;
            4'd2:    k = 3'd3;
            4'd3:    k = 3'd2;
            4'd4:    k = 3'd5;
            4'd5:    k = 3'd0;
            4'd6:    k = 3'd3;
            4'd7:    k = 3'd5;
            4'd8:    k = 3'd1;
            4'd9:    k = 3'd4;
            4'd10:   k = 3'd6;
            4'd11:   k = 3'd2;
            4'd12:   k = 3'd4;
            default: k = 3'd5;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/core/dcut_weekday.sv
// Four-stage weekday unit: weekday of day 1 of a month from March to December by Sakamoto's method.
// Depends on dcut_pkg (constants, month key).
module dcut_weekday
    import dcut_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    output logic        o_done,
    output logic [2:0]  o_wday
);

    logic        r_v1, r_v2, r_v3, r_v4;
    logic [12:0] r_yy1, r_yy2;
    logic [2:0]  r_key1, r_key2;
    logic [5:0]  r_q100;
    logic [12:0] r_sum;
    logic [2:0]  r_wday;

    logic [25:0] n_prod;
    logic [12:0] n_sum;
    logic [4:0]  n_fold1;
    logic [3:0]  n_fold2;
    logic [2:0]  n_wday;

    // year / 100 by reciprocal multiply
    assign n_prod = 26'(r_yy1) * 26'(RECIP100);

    // yy + yy/4 - yy/100 + yy/400 + key + 1
    assign n_sum = r_yy2 + (r_yy2 >> 2) - 13'(r_q100) + 13'(r_q100 >> 2)
                 + 13'(r_key2) + 13'd1;

    // mod 7 by folding octal digits (8 is 1 mod 7)
    assign n_fold1 = 5'(r_sum[2:0]) + 5'(r_sum[5:3]) + 5'(r_sum[8:6])
                   + 5'(r_sum[11:9]) + 5'(r_sum[12]);
    assign n_fold2 = 4'(n_fold1[2:0]) + 4'(n_fold1[4:3]);
    assign n_wday  = (n_fold2 >= 4'd7) ? 3'(n_fold2 - 4'd7) : n_fold2[2:0];

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_yy1  <= 13'(i_year) + YEAR_SHIFT;
        r_key1 <= month_key(i_month);
        r_yy2  <= r_yy1;
        r_key2 <= r_key1;
        r_q100 <= n_prod[24:19];
        r_sum  <= n_sum;
        r_wday <= n_wday;
    end

    assign o_done = r_v4;
    assign o_wday = r_wday;

endmodule

FILE: rtl/core/dcut_scan.sv
// Day-by-day Sunday search: one day and one weekday step per cycle.
// Depends on dcut_pkg (t_scan_ctl, DAY_LAST).
module dcut_scan
    import dcut_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_scan_ctl  i_ctl,
    input  logic [2:0] i_wday1,
    output logic       o_done,
    output logic [4:0] o_day
);

    logic       r_busy, r_down, r_done;
    logic [1:0] r_nth, r_cnt;
    logic [4:0] r_day;
    logic [2:0] r_wd;

    logic [3:0] n_wd31;
    logic [1:0] n_cnt;
    logic       n_stop;

    // weekday of day 31 is day 1 plus 30, i.e. plus 2 mod 7
    assign n_wd31 = 4'(i_wday1) + 4'd2;
    assign n_cnt  = r_cnt + 2'd1;
    assign n_stop = r_down ? (r_day <= 5'd1 || r_wd == 3'd0)
                           : ((r_wd == 3'd0 && n_cnt == r_nth) || r_day == DAY_LAST);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && n_stop;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (n_stop) begin
                r_busy <= 1'b0;
            end
        end
    end

    // day and weekday counters
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_down <= i_ctl.down;
            r_nth  <= i_ctl.nth;
            r_cnt  <= 2'd0;
            if (i_ctl.down) begin
                r_day <= DAY_LAST;
                r_wd  <= (n_wd31 >= 4'd7) ? 3'(n_wd31 - 4'd7) : n_wd31[2:0];
            end else begin
                r_day <= 5'd1;
                r_wd  <= i_wday1;
            end
        end else if (r_busy && !n_stop) begin
            if (r_down) begin
                r_day <= r_day - 5'd1;
                r_wd  <= r_wd - 3'd1;
            end else begin
                r_day <= r_day + 5'd1;
                r_wd  <= (r_wd == 3'd6) ? 3'd0 : r_wd + 3'd1;
                if (r_wd == 3'd0) begin
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_day  = r_day;

endmodule

FILE: rtl/core/dst_check_and_utc_convert.sv
// Summer-time check and local-to-UTC hour conversion for four radio time sources.
// The beat passes the weekday unit, then the day-by-day Sunday search (last Sunday counted
// down from day 31, n-th Sunday counted up from day 1), then the result register, which waits while the output stalls.
// One beat in flight; the next is taken the cycle after the result loads.
// Reset (synchronous, active low) returns the sequencer to idle, result empty.
module dst_check_and_utc_convert
    import dcut_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_src_select,
    input  logic [11:0] i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [11:0] o_year_out,
    output logic        o_summer_flag
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WDAY = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [1:0]  r_src;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day, r_hour, r_sw_day;
    logic        r_out_valid;
    logic [4:0]  r_hour_out;
    logic [5:0]  r_day_out;
    logic [3:0]  r_month_out;
    logic [11:0] r_year_out;
    logic        r_summer_out;

    logic        accept, us_in, wk_start, wk_done, sc_done, out_free, us, summer, sh_ge, eh_lt;
    logic [3:0]  tgt_month, sub;
    logic [2:0]  wk_wday;
    logic [4:0]  sc_day;
    logic [6:0]  h7;
    logic [4:0]  n_hour;
    logic [5:0]  n_day;
    t_scan_ctl   sc_ctl;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign us_in    = (i_src_select == SRC_WWVB);
    assign wk_start = accept;
    // month whose switch Sunday decides the beat
    assign tgt_month = (i_month_in == MON_MAR) ? MON_MAR : (us_in ? MON_NOV : MON_OCT);

    dcut_weekday u_weekday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wk_start),
        .i_year  (i_year_in),
        .i_month (tgt_month),
        .o_done  (wk_done),
        .o_wday  (wk_wday)
    );

    // scan request: EU last Sunday, US second Sunday of March or first of November
    assign us           = (r_src == SRC_WWVB);
    assign sc_ctl.start = (r_state == ST_WDAY) && wk_done;
    assign sc_ctl.down  = !us;
    assign sc_ctl.nth   = (r_month == MON_MAR) ? 2'd2 : 2'd1;

    dcut_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sc_ctl),
        .i_wday1 (wk_wday),
        .o_done  (sc_done),
        .o_day   (sc_day)
    );

    // summer decision against the switch Sunday
    always_comb begin
        sh_ge = (r_src == SRC_DCF77 || us) ? (r_hour >= 5'd2) : (r_hour >= 5'd1);
        eh_lt = (r_src == SRC_DCF77) ? (r_hour < 5'd3) : (r_hour < 5'd2);
        if (r_src == SRC_JJY) begin
            summer = 1'b0;
        end else if (r_month > MON_MAR && r_month < MON_OCT) begin
            summer = 1'b1;
        end else if (r_month < MON_MAR) begin
            summer = 1'b0;
        end else if (us ? (r_month > MON_NOV) : (r_month > MON_OCT)) begin
            summer = 1'b0;
        end else if (r_month == MON_MAR) begin
            summer = (r_day != r_sw_day) ? (r_day > r_sw_day) : sh_ge;
        end else if (us && r_month == MON_OCT) begin
            summer = 1'b1;
        end else begin
            summer = (r_day != r_sw_day) ? (r_day < r_sw_day) : eh_lt;
        end
    end

    // hour offset to UTC and single wrap
    always_comb begin
        case (r_src)
            SRC_DCF77: sub = summer ? 4'd2 : 4'd1;
            SRC_MSF60: sub = summer ? 4'd1 : 4'd0;
            SRC_JJY:   sub = 4'd9;
            default:   sub = 4'd0;
        endcase
        h7 = {2'b00, r_hour} - {3'b000, sub};
        if (h7[6]) begin
            n_hour = 5'(h7 + 7'(HOURS_PER_DAY));
            n_day  = {1'b0, r_day} - 6'd1;
        end else if (h7 >= 7'(HOURS_PER_DAY)) begin
            n_hour = 5'(h7 - 7'(HOURS_PER_DAY));
            n_day  = {1'b0, r_day} + 6'd1;
        end else begin
            n_hour = h7[4:0];
            n_day  = {1'b0, r_day};
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_WDAY;
            ST_WDAY: if (wk_done) n_state = ST_SCAN;
            ST_SCAN: if (sc_done) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input capture, switch day and result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src   <= i_src_select;
            r_year  <= i_year_in;
            r_month <= i_month_in;
            r_day   <= i_day_in;
            r_hour  <= i_hour_in;
        end
        if (sc_done) begin
            r_sw_day <= sc_day;
        end
        if (r_state == ST_OUT && out_free) begin
            r_hour_out   <= n_hour;
            r_day_out    <= n_day;
            r_month_out  <= r_month;
            r_year_out   <= r_year;
            r_summer_out <= summer;
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_hour_out    = r_hour_out;
    assign o_day_out     = r_day_out;
    assign o_month_out   = r_month_out;
    assign o_year_out    = r_year_out;
    assign o_summer_flag = r_summer_out;

    // checks
    a_wk_done_in_wday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wk_done |-> r_state == ST_WDAY)
        else $error("weekday result outside weekday phase");

    a_sc_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_done |-> r_state == ST_SCAN)
        else $error("scan result outside scan phase");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hour_out < HOURS_PER_DAY)
        else $error("UTC hour out of range");

    a_summer_months: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_summer_flag) |-> (o_month_out >= MON_MAR && o_month_out <= MON_NOV))
        else $error("summer flagged outside March to November");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for dst_check_and_utc_convert: a directed table, then random beats.
// Depends on dcut_pkg and the block under rtl/core; expected results come from a local predictor.
module tb;
    import dcut_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_CYCLES  = 200;
    localparam int JJY_OFFSET   = -9;
    localparam int DIR_N        = 23;
    // Sakamoto month keys, January first
    localparam int MKEY [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    typedef struct packed {
        logic [1:0]  src;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
    } t_local_stamp;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic        summer;
    } t_utc_stamp;

    // typed = 1: hour, day and summer below are the expected values
    typedef struct packed {
        t_local_stamp stamp;
        logic         typed;
        logic [4:0]   hour;
        logic [5:0]   day;
        logic         summer;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_src_select = '0;
    logic [11:0] i_year_in = '0;
    logic [3:0]  i_month_in = '0;
    logic [4:0]  i_day_in = '0;
    logic [4:0]  i_hour_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_day_out;
    logic [3:0]  o_month_out;
    logic [11:0] o_year_out;
    logic        o_summer_flag;

    t_utc_stamp utc_expect_q [$];
    int         n_errors = 0;
    int         cycle_cnt = 0;
    bit         idle_en = 1'b1;
    bit         hold_req = 1'b0;

    // Switch days around 2024 (EU: Mar 31 / Oct 27, US: Mar 10 / Nov 3) plus edge cases
    t_dir_row dir_tab [DIR_N] = '{
        '{'{SRC_DCF77, 12'd2024, 4'd3,  5'd31, 5'd1},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_DCF77, 12'd2024, 4'd3,  5'd31, 5'd2},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_DCF77, 12'd2024, 4'd10, 5'd27, 5'd2},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_DCF77, 12'd2024, 4'd10, 5'd27, 5'd3},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_MSF60, 12'd2024, 4'd3,  5'd31, 5'd0},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_MSF60, 12'd2024, 4'd3,  5'd31, 5'd1},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_MSF60, 12'd2024, 4'd10, 5'd27, 5'd1},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_MSF60, 12'd2024, 4'd10, 5'd27, 5'd2},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_WWVB,  12'd2024, 4'd3,  5'd10, 5'd1},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_WWVB,  12'd2024, 4'd3,  5'd10, 5'd2},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_WWVB,  12'd2024, 4'd11, 5'd3,  5'd1},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_WWVB,  12'd2024, 4'd11, 5'd3,  5'd2},  1'b0, 5'd0,  6'd0,  1'b0},
        // US October is summer throughout
        '{'{SRC_WWVB,  12'd2024, 4'd10, 5'd31, 5'd12}, 1'b1, 5'd12, 6'd31, 1'b1},
        // EU November is never summer
        '{'{SRC_DCF77, 12'd2024, 4'd11, 5'd1,  5'd12}, 1'b1, 5'd11, 6'd1,  1'b0},
        // months out of range count as winter
        '{'{SRC_DCF77, 12'd2024, 4'd0,  5'd15, 5'd0},  1'b1, 5'd23, 6'd14, 1'b0},
        '{'{SRC_MSF60, 12'd2024, 4'd15, 5'd31, 5'd31}, 1'b1, 5'd7,  6'd32, 1'b0},
        // day zero wrapping backwards lands on 63
        '{'{SRC_JJY,   12'd0,    4'd7,  5'd0,  5'd0},  1'b1, 5'd15, 6'd63, 1'b0},
        '{'{SRC_WWVB,  12'd4095, 4'd12, 5'd31, 5'd23}, 1'b1, 5'd23, 6'd31, 1'b0},
        '{'{SRC_JJY,   12'd4095, 4'd1,  5'd31, 5'd23}, 1'b1, 5'd14, 6'd31, 1'b0},
        '{'{SRC_DCF77, 12'd0,    4'd3,  5'd31, 5'd5},  1'b0, 5'd0,  6'd0,  1'b0},
        '{'{SRC_DCF77, 12'd2024, 4'd7,  5'd31, 5'd23}, 1'b1, 5'd21, 6'd31, 1'b1},
        '{'{SRC_DCF77, 12'd2024, 4'd1,  5'd1,  5'd0},  1'b1, 5'd23, 6'd0,  1'b0},
        // hour above 23 wraps forwards once
        '{'{SRC_WWVB,  12'd2024, 4'd6,  5'd5,  5'd30}, 1'b1, 5'd6,  6'd6,  1'b1}
    };

    dst_check_and_utc_convert dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_src_select  (i_src_select),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_hour_in     (i_hour_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hour_out    (o_hour_out),
        .o_day_out     (o_day_out),
        .o_month_out   (o_month_out),
        .o_year_out    (o_year_out),
        .o_summer_flag (o_summer_flag)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Weekday with Sunday as 0; the year is pushed up by a full 400-year cycle
    function automatic int unsigned weekday(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
        int unsigned yy;
        yy = y + 400;
        if (m < 3) yy -= 1;
        return (yy + yy / 4 - yy / 100 + yy / 400 + MKEY[(m - 1) % 12] + d) % 7;
    endfunction

    function automatic int unsigned last_sunday(input int unsigned y, input int unsigned m);
        int unsigned d;
        d = 31;
        while (d > 1 && weekday(d, m, y) != 0) d--;
        return d;
    endfunction

    function automatic int unsigned nth_sunday(input int unsigned y, input int unsigned m,
                                               input int unsigned n);
        int unsigned cnt;
        cnt = 0;
        for (int unsigned d = 1; d <= 31; d++) begin
            if (weekday(d, m, y) == 0) begin
                cnt++;
                if (cnt == n) return d;
            end
        end
        return 31;
    endfunction

    // Sunday on which summer starts (start = 1) or ends
    function automatic int unsigned switch_day(input logic [1:0] src, input int unsigned y,
                                               input bit start);
        if (src == SRC_WWVB) return start ? nth_sunday(y, 3, 2) : nth_sunday(y, 11, 1);
        return last_sunday(y, start ? 3 : 10);
    endfunction

    function automatic bit in_summer(input t_local_stamp s);
        int unsigned sd, ed, sh, eh;
        bit us;
        us = (s.src == SRC_WWVB);
        if (s.src == SRC_JJY) return 1'b0;
        sd = switch_day(s.src, s.year, 1'b1);
        ed = switch_day(s.src, s.year, 1'b0);
        sh = (s.src == SRC_MSF60) ? 1 : 2;
        eh = (s.src == SRC_DCF77) ? 3 : 2;
        if (s.month > MON_MAR && s.month < MON_OCT) return 1'b1;
        if (s.month < MON_MAR) return 1'b0;
        if (us ? (s.month > MON_NOV) : (s.month > MON_OCT)) return 1'b0;
        if (s.month == MON_MAR) begin
            if (s.day != sd) return s.day > sd;
            return s.hour >= sh;
        end
        if (us && s.month == MON_OCT) return 1'b1;
        if (s.day != ed) return s.day < ed;
        return s.hour < eh;
    endfunction

    function automatic t_utc_stamp utc_predict(input t_local_stamp s);
        t_utc_stamp r;
        int hh;
        logic [5:0] dd;
        r.summer = in_summer(s);
        hh = int'(s.hour);
        dd = {1'b0, s.day};
        case (s.src)
            SRC_DCF77: hh += r.summer ? -2 : -1;
            SRC_MSF60: hh += r.summer ? -1 : 0;
            SRC_JJY:   hh += JJY_OFFSET;
            default:   ;
        endcase
        // single wrap, day moves modulo 64
        if (hh < 0) begin
            hh += int'(HOURS_PER_DAY);
            dd = dd - 6'd1;
        end else if (hh >= int'(HOURS_PER_DAY)) begin
            hh -= int'(HOURS_PER_DAY);
            dd = dd + 6'd1;
        end
        r.hour  = hh[4:0];
        r.day   = dd;
        r.month = s.month;
        r.year  = s.year;
        return r;
    endfunction

    // Mostly switch months and days near the switch Sundays; some raw noise
    function automatic t_local_stamp rand_stamp();
        t_local_stamp s;
        int unsigned sw;
        s.src = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 8) begin
            s.year  = 12'($urandom);
            s.month = 4'($urandom);
            s.day   = 5'($urandom);
            s.hour  = 5'($urandom);
            return s;
        end
        s.year = 12'($urandom_range(1, 4095));
        case ($urandom_range(0, 9))
            0, 1, 2: s.month = MON_MAR;
            3, 4:    s.month = MON_OCT;
            5:       s.month = MON_NOV;
            default: s.month = 4'($urandom_range(1, 12));
        endcase
        if ($urandom_range(0, 1) == 1) begin
            sw = switch_day(s.src, s.year, s.month == MON_MAR);
            s.day = 5'(sw + $urandom_range(0, 2) - 1);
        end else begin
            s.day = 5'($urandom_range(1, 31));
        end
        s.hour = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 4))
                                              : 5'($urandom_range(0, 23));
        return s;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Offer one beat, optionally after a short gap, and log its expected result on accept
    task automatic send_beat(input t_local_stamp s, input t_utc_stamp want);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_src_select <= s.src;
        i_year_in    <= s.year;
        i_month_in   <= s.month;
        i_day_in     <= s.day;
        i_hour_in    <= s.hour;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        utc_expect_q.push_back(want);
    endtask

    task automatic send_random(input int n);
        t_local_stamp s;
        for (int k = 0; k < n; k++) begin
            s = rand_stamp();
            send_beat(s, utc_predict(s));
        end
    endtask

    // Receiver: one long hold on request, otherwise short random stall bursts
    initial begin : receiver
        int burst;
        int held;
        burst = 0;
        held  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && held < HOLD_CYCLES) begin
                held++;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 4) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_utc_stamp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (utc_expect_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, hour %0d day %0d",
                         $time, o_hour_out, o_day_out);
                n_errors++;
            end else begin
                want = utc_expect_q.pop_front();
                check_field("hour_out", want.hour, o_hour_out);
                check_field("day_out", want.day, o_day_out);
                check_field("month_out", want.month, o_month_out);
                check_field("year_out", want.year, o_year_out);
                check_field("summer_flag", want.summer, o_summer_flag);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, utc_expect_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        t_utc_stamp want;
        t_local_stamp s;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int k = 0; k < DIR_N; k++) begin
            s    = dir_tab[k].stamp;
            want = utc_predict(s);
            if (dir_tab[k].typed) begin
                want.hour   = dir_tab[k].hour;
                want.day    = dir_tab[k].day;
                want.summer = dir_tab[k].summer;
            end
            send_beat(s, want);
        end

        send_random(150);

        // receiver holds off while beats keep coming, so the input backs up
        hold_req = 1'b1;
        send_random(12);

        // sender pauses until everything has come out
        i_in_valid <= 1'b0;
        while (utc_expect_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        send_random(200);

        // last stretch at full rate on both sides
        idle_en = 1'b0;
        send_random(150);

        i_in_valid <= 1'b0;
        while (utc_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
